@@ hw/rtl/ifhg_pkg.sv @@
package ifhg_pkg;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MTU      = 3'd0;
	localparam logic [2:0] REG_SRC_ADDR = 3'd1;
	localparam logic [2:0] REG_DST_ADDR = 3'd2;
	localparam logic [2:0] REG_IDENT    = 3'd3;
	localparam logic [2:0] REG_TTL      = 3'd4;
	localparam logic [2:0] REG_TOS      = 3'd5;
	localparam logic [2:0] REG_PROTO    = 3'd6;

	localparam logic [15:0] MTU_RESET   = 16'd1500;
	localparam logic [15:0] IDENT_RESET = 16'd31415;
	localparam logic [7:0]  TTL_RESET   = 8'd255;
	localparam logic [7:0]  TOS_RESET   = 8'd0;
	localparam logic [7:0]  PROTO_RESET = 8'd6;

	localparam logic [15:0] HDR_BYTES = 16'd20;
	localparam logic [15:0] MIN_MTU   = 16'd28;
	localparam logic [15:0] MIN_CAP   = 16'd8;
	localparam logic [7:0]  VER_IHL   = 8'h45;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	typedef struct packed {
		logic [15:0] mtu;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] ident;
		logic [7:0]  ttl;
		logic [7:0]  tos;
		logic [7:0]  proto;
	} cfg_t;

	// per-fragment decision handed from the split stage to the header stage
	typedef struct packed {
		logic        err;
		logic [15:0] take;
		logic        mf;
		logic [12:0] off;
	} frag_t;

endpackage

@@ hw/rtl/ifhg_cfg_regs.sv @@
module ifhg_cfg_regs
	import ifhg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic [18:0]        static_sum
);

	cfg_t        cfg_q;
	logic [18:0] static_sum_q;
	logic [2:0]  idx;
	logic        wr_en;
	logic [18:0] static_sum_d;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mtu      <= MTU_RESET;
			cfg_q.src_addr <= 32'd0;
			cfg_q.dst_addr <= 32'd0;
			cfg_q.ident    <= IDENT_RESET;
			cfg_q.ttl      <= TTL_RESET;
			cfg_q.tos      <= TOS_RESET;
			cfg_q.proto    <= PROTO_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MTU:      cfg_q.mtu      <= pwdata[15:0];
				REG_SRC_ADDR: cfg_q.src_addr <= pwdata;
				REG_DST_ADDR: cfg_q.dst_addr <= pwdata;
				REG_IDENT:    cfg_q.ident    <= pwdata[15:0];
				REG_TTL:      cfg_q.ttl      <= pwdata[7:0];
				REG_TOS:      cfg_q.tos      <= pwdata[7:0];
				REG_PROTO:    cfg_q.proto    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MTU:      prdata = {16'd0, cfg_q.mtu};
			REG_SRC_ADDR: prdata = cfg_q.src_addr;
			REG_DST_ADDR: prdata = cfg_q.dst_addr;
			REG_IDENT:    prdata = {16'd0, cfg_q.ident};
			REG_TTL:      prdata = {24'd0, cfg_q.ttl};
			REG_TOS:      prdata = {24'd0, cfg_q.tos};
			REG_PROTO:    prdata = {24'd0, cfg_q.proto};
			default:      prdata = '0;
		endcase
	end

	// sum of the seven header words that depend on configuration only
	assign static_sum_d = {3'd0, VER_IHL, cfg_q.tos}
		+ {3'd0, cfg_q.ident}
		+ {3'd0, cfg_q.ttl, cfg_q.proto}
		+ {3'd0, cfg_q.src_addr[31:16]}
		+ {3'd0, cfg_q.src_addr[15:0]}
		+ {3'd0, cfg_q.dst_addr[31:16]}
		+ {3'd0, cfg_q.dst_addr[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_sum_q <= '0;
		end else begin
			static_sum_q <= static_sum_d;
		end
	end

	assign cfg        = cfg_q;
	assign static_sum = static_sum_q;

endmodule

@@ hw/rtl/ifhg_frag_ctrl.sv @@
module ifhg_frag_ctrl
	import ifhg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        command,
	input  logic [15:0] data_length,
	input  logic [15:0] mtu,
	input  logic        adv,
	output logic        valid_s1,
	output frag_t       frag_s1
);

	logic [15:0] remaining_q;
	logic [12:0] next_off_q;
	logic        pending_q;
	logic        v_s1;
	frag_t       f_s1;

	logic        accept;
	logic [15:0] rem;
	logic [15:0] cap;
	frag_t       f_d;
	logic [12:0] off_adv;

	assign cmd_ready = ~v_s1 | adv;
	assign accept    = cmd_valid & cmd_ready;

	always_comb begin
		rem     = (command == CMD_START) ? data_length : remaining_q;
		cap     = (mtu < MIN_MTU) ? MIN_CAP : (mtu - HDR_BYTES);
		f_d.err = ((command == CMD_START) && (data_length == 16'd0)) ||
			((command == CMD_NEXT) && !pending_q);
		f_d.off = (command == CMD_START) ? 13'd0 : next_off_q;
		if (f_d.err) begin
			f_d.take = '0;
			f_d.mf   = 1'b0;
			f_d.off  = '0;
		end else if (rem > cap) begin
			f_d.take = {cap[15:3], 3'b000};
			f_d.mf   = 1'b1;
		end else begin
			f_d.take = rem;
			f_d.mf   = 1'b0;
		end
		off_adv = f_d.off + f_d.take[15:3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			next_off_q  <= '0;
			pending_q   <= 1'b0;
		end else if (accept) begin
			if (f_d.err) begin
				// drop any datagram on a zero-length start, hold on a stray next
				if (command == CMD_START) begin
					remaining_q <= '0;
					next_off_q  <= '0;
					pending_q   <= 1'b0;
				end
			end else begin
				next_off_q  <= off_adv;
				pending_q   <= f_d.mf;
				remaining_q <= f_d.mf ? (rem - f_d.take) : 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_ready) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_s1 <= f_d;
		end
	end

	assign valid_s1 = v_s1;
	assign frag_s1  = f_s1;

	a_pending_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (remaining_q != 16'd0))
		else $error("pending datagram with no bytes left");

	a_idle_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (remaining_q == 16'd0))
		else $error("bytes left with no datagram pending");

	a_mf_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !f_d.err && f_d.mf) |=> pending_q)
		else $error("non-final fragment did not leave the datagram pending");

endmodule

@@ hw/rtl/ifhg_hdr_csum.sv @@
module ifhg_hdr_csum
	import ifhg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  frag_t       frag_s1,
	input  logic [18:0] static_sum,
	output logic        adv,
	output logic        frag_valid,
	input  logic        frag_ready,
	output logic [15:0] fragment_length,
	output logic [12:0] fragment_offset,
	output logic        more_fragments,
	output logic [15:0] total_length,
	output logic [15:0] header_checksum,
	output logic        error
);

	logic        v_s2;
	logic [15:0] len_s2;
	logic [12:0] off_s2;
	logic        mf_s2;
	logic [15:0] tot_s2;
	logic [15:0] csum_s2;
	logic        err_s2;

	logic [15:0] total;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign adv = ~v_s2 | frag_ready;

	always_comb begin
		total = frag_s1.take + HDR_BYTES;
		sum   = {1'b0, static_sum} + {4'd0, total} + {4'd0, 2'b00, frag_s1.mf, frag_s1.off};
		fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			err_s2  <= frag_s1.err;
			len_s2  <= frag_s1.take;
			off_s2  <= frag_s1.off;
			mf_s2   <= frag_s1.mf;
			tot_s2  <= frag_s1.err ? 16'd0 : total;
			csum_s2 <= frag_s1.err ? 16'd0 : ~fold2;
		end
	end

	assign frag_valid      = v_s2;
	assign fragment_length = len_s2;
	assign fragment_offset = off_s2;
	assign more_fragments  = mf_s2;
	assign total_length    = tot_s2;
	assign header_checksum = csum_s2;
	assign error           = err_s2;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && err_s2) |-> (len_s2 == 16'd0 && off_s2 == 13'd0 && !mf_s2 &&
		tot_s2 == 16'd0 && csum_s2 == 16'd0))
		else $error("error result carries non-zero fields");

	a_total_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !err_s2) |-> (tot_s2 == len_s2 + HDR_BYTES))
		else $error("total length does not match fragment length");

	a_mf_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && mf_s2) |-> (len_s2[2:0] == 3'b000 && len_s2 != 16'd0))
		else $error("non-final fragment not a multiple of eight bytes");

endmodule

@@ hw/rtl/ipv4_fragment_header_generator.sv @@
// IPv4 fragment header generator.
// Command channel (cmd_valid/cmd_ready, command, data_length): a start command
// loads the datagram length and yields its first fragment; each next command
// yields the following fragment. Every command gives exactly one transfer on
// the fragment channel (frag_valid/frag_ready), carrying length, offset in
// 8-byte units, more-fragments flag, total length and header checksum, or
// error with all other fields zero for a next with nothing pending or a start
// of zero length.
// Path: command transfer, split stage register, then checksum stage register,
// then fragment valid. Throughput: one command per cycle while the output is
// not stalled, through the two pipeline registers; the split decision and the
// datagram state update both happen in the cycle of the command transfer.
// Stall: while frag_ready is low the result is held; the split stage still
// takes one more command, then cmd_ready drops until the output drains.
// Reset: arst_n clears the pipeline and the datagram state (nothing pending)
// and loads the register defaults (MTU 1500, ident 31415, TTL 255, proto 6).
// Registers sit on the APB port at byte address 4*index; write them only
// while no fragment is in flight.
module ipv4_fragment_header_generator
	import ifhg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// command channel
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               command,
	input  logic [15:0]        data_length,
	// fragment channel
	output logic               frag_valid,
	input  logic               frag_ready,
	output logic [15:0]        fragment_length,
	output logic [12:0]        fragment_offset,
	output logic               more_fragments,
	output logic [15:0]        total_length,
	output logic [15:0]        header_checksum,
	output logic               error
);

	cfg_t        cfg;
	logic [18:0] static_sum;
	logic        adv;
	logic        valid_s1;
	frag_t       frag_s1;

	// register file plus the pre-summed constant part of the header
	ifhg_cfg_regs u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.static_sum (static_sum)
	);

	// stage 1: split decision and datagram state
	ifhg_frag_ctrl u_frag_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.data_length (data_length),
		.mtu         (cfg.mtu),
		.adv         (adv),
		.valid_s1    (valid_s1),
		.frag_s1     (frag_s1)
	);

	// stage 2: total length, checksum fold, output register
	ifhg_hdr_csum u_hdr_csum (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.frag_s1         (frag_s1),
		.static_sum      (static_sum),
		.adv             (adv),
		.frag_valid      (frag_valid),
		.frag_ready      (frag_ready),
		.fragment_length (fragment_length),
		.fragment_offset (fragment_offset),
		.more_fragments  (more_fragments),
		.total_length    (total_length),
		.header_checksum (header_checksum),
		.error           (error)
	);

endmodule

@@ test/tb_ipv4_fragment_header_generator.sv @@
module tb_ipv4_fragment_header_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import ifhg_pkg::*;

	// Watchdog budget: roughly 860 commands, each one a single fragment, with
	// idle and stall cycles on both sides in some phases.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// Extra settling wait after the pipeline empties, before touching registers.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_DATA_LEN = 65515;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_BUDGET  = 100;
	// Keep datagrams short so that a phase sees many starts, not one long train.
	localparam int unsigned MAX_FRAGS_PER_DGRAM = 64;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// One pending command; hold_for_drain keeps it back until every fragment
	// already requested has come out.
	typedef struct packed {
		logic        cmd;
		logic [15:0] dlen;
		logic        hold_for_drain;
	} frag_request_t;

	typedef struct packed {
		logic [15:0] len;
		logic [12:0] off;
		logic        mf;
		logic [15:0] total;
		logic [15:0] csum;
		logic        err;
	} frag_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	logic               command = CMD_START;
	logic [15:0]        data_length = '0;
	logic               frag_valid;
	logic               frag_ready = 1'b0;
	logic [15:0]        fragment_length;
	logic [12:0]        fragment_offset;
	logic               more_fragments;
	logic [15:0]        total_length;
	logic [15:0]        header_checksum;
	logic               error;

	// Register shadow, kept in step with every APB write.
	cfg_t reg_shadow = '{
		mtu:      MTU_RESET,
		src_addr: '0,
		dst_addr: '0,
		ident:    IDENT_RESET,
		ttl:      TTL_RESET,
		tos:      TOS_RESET,
		proto:    PROTO_RESET
	};

	// Datagram state as the block should hold it.
	logic [15:0] dgram_remaining = '0;
	logic [12:0] dgram_offset = '0;
	logic        dgram_pending = 1'b0;

	frag_request_t request_queue[$];
	frag_result_t  expected_fragments[$];
	frag_request_t next_req;
	logic          cmd_taken = 1'b0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;

	ipv4_fragment_header_generator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.command         (command),
		.data_length     (data_length),
		.frag_valid      (frag_valid),
		.frag_ready      (frag_ready),
		.fragment_length (fragment_length),
		.fragment_offset (fragment_offset),
		.more_fragments  (more_fragments),
		.total_length    (total_length),
		.header_checksum (header_checksum),
		.error           (error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Per-fragment byte limit; below the smallest sensible MTU fall back to
	// eight bytes so that every fragment still moves the datagram on.
	function automatic logic [15:0] fragment_cap(logic [15:0] mtu);
		return (mtu < MIN_MTU) ? MIN_CAP : mtu - HDR_BYTES;
	endfunction

	// Work out the fragment that one accepted command should yield, and
	// advance the datagram state.
	function automatic frag_result_t predict_fragment(logic cmd, logic [15:0] dlen);
		frag_result_t res;
		logic [15:0]  cap;
		logic [15:0]  take;
		logic [31:0]  sum;
		res = '0;
		if (cmd == CMD_START) begin
			// A zero-length start clears whatever was in progress and fails.
			if (dlen == 16'd0) begin
				dgram_pending = 1'b0;
				dgram_remaining = '0;
				dgram_offset = '0;
				res.err = 1'b1;
				return res;
			end
			// Any datagram still pending is abandoned here.
			dgram_remaining = dlen;
			dgram_offset = '0;
			dgram_pending = 1'b1;
		end else if (!dgram_pending) begin
			// Next with nothing pending: error, state untouched.
			res.err = 1'b1;
			return res;
		end
		cap = fragment_cap(reg_shadow.mtu);
		if (dgram_remaining > cap) begin
			// Non-final fragments carry a whole number of 8-byte blocks.
			take = cap & 16'hfff8;
			res.mf = 1'b1;
		end else begin
			take = dgram_remaining;
			res.mf = 1'b0;
		end
		res.len = take;
		res.off = dgram_offset;
		res.total = HDR_BYTES + take;
		// Sum the ten header words with the checksum word taken as zero.
		sum = {VER_IHL, reg_shadow.tos} + res.total + reg_shadow.ident
			+ {2'b00, res.mf, res.off} + {reg_shadow.ttl, reg_shadow.proto}
			+ reg_shadow.src_addr[31:16] + reg_shadow.src_addr[15:0]
			+ reg_shadow.dst_addr[31:16] + reg_shadow.dst_addr[15:0];
		// Fold the carries back in twice; the second fold catches the last one.
		sum = {16'h0000, sum[15:0]} + sum[31:16];
		sum = {16'h0000, sum[15:0]} + sum[31:16];
		res.csum = ~sum[15:0];
		dgram_remaining = dgram_remaining - take;
		dgram_offset = dgram_offset + take[15:3];
		if (!res.mf) begin
			dgram_pending = 1'b0;
			dgram_remaining = '0;
		end
		return res;
	endfunction

	// Fragments a datagram of len bytes splits into under the current MTU.
	function automatic int count_fragments(int len);
		int cap;
		int step;
		int rem;
		int frags;
		cap = int'(fragment_cap(reg_shadow.mtu));
		step = cap & 32'hfff8;
		rem = len;
		frags = 1;
		while (rem > cap) begin
			rem -= step;
			frags++;
		end
		return frags;
	endfunction

	// Favour lengths around one to a few fragments and the edges of the
	// per-fragment limit; now and then try anything up to the maximum.
	function automatic int pick_length();
		int cap;
		int step;
		int len;
		int sel;
		cap = int'(fragment_cap(reg_shadow.mtu));
		step = cap & 32'hfff8;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			len = $urandom_range(1, 2 * cap + 16);
		else if (sel < 75)
			len = $urandom_range(1, 8 * cap);
		else if (sel < 92) begin
			case ($urandom_range(0, 4))
				0: len = cap;
				1: len = cap + 1;
				2: len = step;
				3: len = 2 * step + 1;
				default: len = 3 * step;
			endcase
		end else
			len = $urandom_range(1, MAX_DATA_LEN);
		if (len > MAX_DATA_LEN)
			len = MAX_DATA_LEN;
		if (count_fragments(len) > MAX_FRAGS_PER_DGRAM) begin
			len = $urandom_range(1, 4 * cap);
			if (len > MAX_DATA_LEN)
				len = MAX_DATA_LEN;
		end
		return len;
	endfunction

	function automatic void push_request(logic cmd, logic [15:0] dlen, logic hold);
		frag_request_t req;
		req.cmd = cmd;
		req.dlen = dlen;
		req.hold_for_drain = hold;
		request_queue.push_back(req);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge inside the access cycle since pready is tied high.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MTU:      reg_shadow.mtu = val[15:0];
			REG_SRC_ADDR: reg_shadow.src_addr = val;
			REG_DST_ADDR: reg_shadow.dst_addr = val;
			REG_IDENT:    reg_shadow.ident = val[15:0];
			REG_TTL:      reg_shadow.ttl = val[7:0];
			REG_TOS:      reg_shadow.tos = val[7:0];
			REG_PROTO:    reg_shadow.proto = val[7:0];
			default: ;
		endcase
	endtask

	task automatic program_registers(logic [15:0] mtu, logic [31:0] src, logic [31:0] dst,
			logic [15:0] id, logic [7:0] ttl, logic [7:0] tos, logic [7:0] proto);
		reg_write(REG_MTU, {16'h0000, mtu});
		reg_write(REG_SRC_ADDR, src);
		reg_write(REG_DST_ADDR, dst);
		reg_write(REG_IDENT, {16'h0000, id});
		reg_write(REG_TTL, {24'h000000, ttl});
		reg_write(REG_TOS, {24'h000000, tos});
		reg_write(REG_PROTO, {24'h000000, proto});
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 81;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 81;
			end
			default: begin
				send_idle_pct = 22;
				recv_stall_pct = 22;
			end
		endcase
	endtask

	// Wait until every queued command has gone in and every fragment has come
	// out, then let the pipeline settle. Look just after the edge so that the
	// driver and monitor have finished with it.
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (request_queue.size() != 0 || cmd_valid || expected_fragments.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random traffic: mostly whole datagrams with random lengths, some cut
	// short by a fresh start, some overrun by extra next commands, plus stray
	// next commands and zero-length starts.
	task automatic fill_random(int unsigned budget);
		int unsigned issued;
		int          len;
		int          frags;
		int          sel;
		int          extra;
		int          k;
		issued = 0;
		while (issued < budget) begin
			sel = $urandom_range(0, 99);
			if (sel < 6) begin
				push_request(CMD_NEXT, 16'($urandom_range(0, 65535)), 1'b0);
				issued++;
			end else if (sel < 10) begin
				push_request(CMD_START, 16'd0, 1'b0);
				issued++;
			end else begin
				len = pick_length();
				frags = count_fragments(len);
				extra = 0;
				if (sel < 20)
					frags = $urandom_range(1, frags);
				else if (sel < 27)
					extra = $urandom_range(1, 2);
				push_request(CMD_START, len[15:0], $urandom_range(0, 49) == 0);
				for (k = 1; k < frags + extra; k++)
					push_request(CMD_NEXT, 16'($urandom_range(0, 65535)), 1'b0);
				issued += frags + extra;
			end
		end
	endtask

	// Command driver: change inputs on the falling edge. Keep valid and the
	// payload steady until the transfer; after a transfer either present the
	// next command straight away or drop valid and idle.
	always @(negedge clk) begin
		if (!arst_n)
			cmd_valid <= 1'b0;
		else if (!cmd_valid || cmd_taken) begin
			if (request_queue.size() != 0
					&& !(request_queue[0].hold_for_drain && expected_fragments.size() != 0)
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = request_queue.pop_front();
				cmd_valid <= 1'b1;
				command <= next_req.cmd;
				data_length <= next_req.dlen;
			end else
				cmd_valid <= 1'b0;
		end
	end

	// Fragment sink: stall at random per the current phase.
	always @(negedge clk) begin
		if (!arst_n)
			frag_ready <= 1'b0;
		else
			frag_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: sample both channels on the rising edge. Check an outgoing
	// transfer against the oldest expectation before adding the one for an
	// incoming command, so that a spurious fragment can never pair with a
	// command taken at the same edge.
	always @(posedge clk) begin
		frag_result_t want;
		cmd_taken = 1'b0;
		if (arst_n) begin
			if (frag_valid && frag_ready) begin
				if (expected_fragments.size() == 0) begin
					$error("fragment transfer with no fragment outstanding");
					fail_count++;
				end else begin
					want = expected_fragments.pop_front();
					check_field("fragment_length", 32'(want.len), 32'(fragment_length));
					check_field("fragment_offset", 32'(want.off), 32'(fragment_offset));
					check_field("more_fragments", 32'(want.mf), 32'(more_fragments));
					check_field("total_length", 32'(want.total), 32'(total_length));
					check_field("header_checksum", 32'(want.csum), 32'(header_checksum));
					check_field("error", 32'(want.err), 32'(error));
				end
			end
			if (cmd_valid && cmd_ready) begin
				expected_fragments.push_back(predict_fragment(command, data_length));
				cmd_taken = 1'b1;
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_ipv4_fragment_header_generator: FAIL");
		$finish;
	end

	initial begin
		int unsigned phase;
		logic [15:0] rand_mtu;
		int          tail_len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed checks at the reset register values (MTU 1500).
		set_idling(IDLE_NONE);
		push_request(CMD_NEXT, 16'hffff, 1'b0);   // nothing pending
		push_request(CMD_START, 16'd0, 1'b0);     // zero-length start
		push_request(CMD_START, 16'd1, 1'b0);     // smallest datagram
		push_request(CMD_START, 16'd1480, 1'b0);  // exactly one full fragment
		push_request(CMD_START, 16'd1481, 1'b0);  // one byte over the limit
		push_request(CMD_NEXT, 16'd0, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);      // overrun after the last fragment
		push_request(CMD_START, 16'd3000, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		push_request(CMD_START, 16'd100, 1'b1);   // restart mid-datagram, after a drain
		wait_idle();

		// All-ones header fields at the smallest legal MTU.
		program_registers(16'd68, 32'hffffffff, 32'hffffffff, 16'hffff, 8'hff, 8'hff, 8'hff);
		push_request(CMD_START, 16'd49, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		wait_idle();

		// All-zero header fields at the largest MTU: biggest single fragment.
		program_registers(16'hffff, 32'h0, 32'h0, 16'h0, 8'h00, 8'h00, 8'h00);
		push_request(CMD_START, MAX_DATA_LEN[15:0], 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		wait_idle();

		// MTU below the floor: fragments fall back to eight bytes.
		program_registers(16'd20, $urandom, $urandom, 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		push_request(CMD_START, 16'd17, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		wait_idle();

		// MTU change in the middle of a datagram applies from the next fragment.
		reg_write(REG_MTU, 32'd28);
		push_request(CMD_START, 16'd17, 1'b0);
		wait_idle();
		reg_write(REG_MTU, 32'd29);
		push_request(CMD_NEXT, 16'd0, 1'b0);
		wait_idle();

		// Random phases: new registers each time, cycling through the idling
		// patterns. Each phase opens with next commands that pick up the
		// datagram the previous phase left pending under the old registers.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_idling(idle_mode_t'(phase % 4));
			case ($urandom_range(0, 7))
				0: rand_mtu = 16'd68;
				1: rand_mtu = 16'd576;
				2: rand_mtu = 16'd1500;
				3: rand_mtu = 16'd9000;
				4: rand_mtu = 16'hffff;
				5: rand_mtu = 16'($urandom_range(28, 40));
				6: rand_mtu = 16'($urandom_range(0, 27));
				default: rand_mtu = 16'($urandom_range(68, 65535));
			endcase
			program_registers(rand_mtu, $urandom, $urandom, 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			push_request(CMD_NEXT, 16'($urandom_range(0, 65535)), 1'b0);
			push_request(CMD_NEXT, 16'($urandom_range(0, 65535)), 1'b0);
			fill_random(PHASE_BUDGET);
			// Leave a datagram open across the register change; hold its start
			// back until everything before it has drained.
			tail_len = 3 * int'(fragment_cap(reg_shadow.mtu));
			if (tail_len > MAX_DATA_LEN)
				tail_len = MAX_DATA_LEN;
			push_request(CMD_START, tail_len[15:0], 1'b1);
			push_request(CMD_NEXT, 16'($urandom_range(0, 65535)), 1'b0);
			wait_idle();
		end

		if (fail_count == 0)
			$display("tb_ipv4_fragment_header_generator: PASS");
		else
			$display("tb_ipv4_fragment_header_generator: FAIL");
		$finish;
	end

endmodule
